// File: src/hsv_pkg.sv
// shared types and constants for the rgb to hsv pixel converter
// no dependencies; imported by hsv_front, hsv_div and rgb_to_hsv_pixel
package hsv_pkg;

    // channel and result widths
    localparam int CH_W      = 8;
    localparam int HUE_W     = 16;
    localparam int SAT_W     = 8;
    // position in the turn and six times the span both stay at or below 6*255
    localparam int POS_W     = 11;
    // 255 times the span
    localparam int SAT_NUM_W = 16;
    // quotient bits resolved per divider stage
    localparam int DIV_STEP  = 4;
    // stream widths
    localparam int IN_TDATA_W  = 3 * CH_W;
    localparam int OUT_TDATA_W = HUE_W + SAT_W + CH_W;

    // front stage result: everything the dividers and the output stage need
    typedef struct packed {
        logic [CH_W-1:0]      value;
        logic                 hue_zero;
        logic                 sat_zero;
        logic [POS_W-1:0]     pos;
        logic [POS_W-1:0]     den6;
        logic [SAT_NUM_W-1:0] sat_num;
    } front_t;

    // fields that ride alongside the divider stages
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            hue_zero;
        logic            sat_zero;
    } side_t;

endpackage

// File: src/hsv_front.sv
// front stage: max, min, span, hue sector position and divider operands
// depends on hsv_pkg
module hsv_front (
    input  logic                      clk,
    input  logic                      en,
    input  logic [hsv_pkg::CH_W-1:0]  red,
    input  logic [hsv_pkg::CH_W-1:0]  green,
    input  logic [hsv_pkg::CH_W-1:0]  blue,
    output hsv_pkg::front_t           front
);
    import hsv_pkg::*;

    logic            r_max;
    logic            g_max;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] d;
    logic [POS_W-1:0] d2;
    logic [POS_W-1:0] d4;
    logic [POS_W-1:0] d6;
    front_t          front_next;
    front_t          front_reg;

    // largest and smallest channel, red wins ties then green
    always_comb
    begin
        r_max = (red >= green) && (red >= blue);
        g_max = !r_max && (green >= blue);
        if (r_max)
        begin
            hi = red;
        end
        else if (g_max)
        begin
            hi = green;
        end
        else
        begin
            hi = blue;
        end
        lo = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end
        d  = hi - lo;
        d2 = {2'b00, d, 1'b0};
        d4 = {1'b0, d, 2'b00};
        d6 = d2 + d4;
    end

    // position within the turn, where the full turn is six times the span
    always_comb
    begin
        front_next.value    = hi;
        front_next.hue_zero = (d == '0);
        front_next.sat_zero = (hi == '0);
        front_next.den6     = d6;
        front_next.sat_num  = {d, 8'h00} - SAT_NUM_W'(d);
        if (r_max)
        begin
            if (green >= blue)
            begin
                front_next.pos = POS_W'(green) - POS_W'(blue);
            end
            else
            begin
                front_next.pos = d6 - (POS_W'(blue) - POS_W'(green));
            end
        end
        else if (g_max)
        begin
            front_next.pos = d2 + POS_W'(blue) - POS_W'(red);
        end
        else
        begin
            front_next.pos = d4 + POS_W'(red) - POS_W'(green);
        end
    end

    // front pipeline register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// File: src/hsv_div.sv
// pipelined restoring divider, STEP quotient bits per register stage
// depends on hsv_pkg for the house import only
module hsv_div #(
    parameter int DW    = 8,
    parameter int QBITS = 8,
    parameter int NSTG  = 2,
    parameter int STEP  = 4
) (
    input  logic              clk,
    input  logic [NSTG-1:0]   en,
    input  logic [DW-1:0]     rem_in,
    input  logic [QBITS-1:0]  num_in,
    input  logic [DW-1:0]     den_in,
    output logic [QBITS-1:0]  quo
);
    import hsv_pkg::*;

    logic [DW-1:0]    rem_reg [NSTG];
    logic [QBITS-1:0] num_reg [NSTG];
    logic [QBITS-1:0] quo_reg [NSTG];
    logic [DW-1:0]    den_reg [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stage
            logic [DW-1:0]    rem_src;
            logic [QBITS-1:0] num_src;
            logic [QBITS-1:0] quo_src;
            logic [DW-1:0]    den_src;
            logic [DW-1:0]    rem_next;
            logic [QBITS-1:0] num_next;
            logic [QBITS-1:0] quo_next;
            logic [DW:0]      trial;

            // stage operands
            if (s == 0)
            begin : g_first
                assign rem_src = rem_in;
                assign num_src = num_in;
                assign quo_src = '0;
                assign den_src = den_in;
            end
            else
            begin : g_later
                assign rem_src = rem_reg[s-1];
                assign num_src = num_reg[s-1];
                assign quo_src = quo_reg[s-1];
                assign den_src = den_reg[s-1];
            end

            // shift in one numerator bit, compare and subtract, per quotient bit
            always_comb
            begin
                rem_next = rem_src;
                num_next = num_src;
                quo_next = quo_src;
                trial    = '0;
                for (int j = 0; j < STEP; j++)
                begin
                    if (s * STEP + j < QBITS)
                    begin
                        trial    = {rem_next, num_next[QBITS-1]};
                        num_next = {num_next[QBITS-2:0], 1'b0};
                        if (trial >= {1'b0, den_src})
                        begin
                            rem_next = DW'(trial - {1'b0, den_src});
                            quo_next = {quo_next[QBITS-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = trial[DW-1:0];
                            quo_next = {quo_next[QBITS-2:0], 1'b0};
                        end
                    end
                end
            end

            // stage register
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    num_reg[s] <= num_next;
                    quo_reg[s] <= quo_next;
                    den_reg[s] <= den_src;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NSTG-1];

endmodule

// File: src/rgb_to_hsv_pixel.sv
// rgb to hsv pixel converter, top level
// pipeline: ceil(HUE_BITS/4) + 2 register stages: front, divider stages, output
// throughput: one pixel per clock while m_axis_tready is high; the hue divider resolves
// 4 quotient bits per stage
// each stage holds when its successor is full and stalled, bubbles close up
// reset clears the stage valid bits only; data registers are not reset; uses hsv_pkg
module rgb_to_hsv_pixel #(
    parameter int HUE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [hsv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hue [15:0], saturation [23:16], value [31:24]
    output logic [hsv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import hsv_pkg::*;

    localparam int NS = (HUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NT = NS + 2;

    logic [NT-1:0]       valid_reg;
    logic [NT-1:0]       valid_next;
    logic [NT-1:0]       en;
    front_t              front;
    side_t               side_reg [NS];
    logic [HUE_BITS-1:0] hue_q;
    logic [SAT_W-1:0]    sat_q;
    logic [HUE_W-1:0]    hue_next;
    logic [SAT_W-1:0]    sat_next;
    logic [HUE_W-1:0]    hue_reg;
    logic [SAT_W-1:0]    sat_reg;
    logic [CH_W-1:0]     value_reg;

    // stage enables: a stage loads when it is empty or its successor moves
    always_comb
    begin
        en[NT-1] = !valid_reg[NT-1] || m_axis_tready;
        for (int i = NT - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_axis_tvalid : valid_reg[0];
        for (int i = 1; i < NT; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NT-1];

    // max, min and divider operands
    hsv_front u_front (
        .clk   (clk),
        .en    (en[0]),
        .red   (s_axis_tdata[CH_W-1:0]),
        .green (s_axis_tdata[2*CH_W-1:CH_W]),
        .blue  (s_axis_tdata[3*CH_W-1:2*CH_W]),
        .front (front)
    );

    // hue: pos * 2^HUE_BITS / (6 * span), pos is already below the divisor
    hsv_div #(
        .DW    (POS_W),
        .QBITS (HUE_BITS),
        .NSTG  (NS),
        .STEP  (DIV_STEP)
    ) u_hue_div (
        .clk    (clk),
        .en     (en[NS:1]),
        .rem_in (front.pos),
        .num_in ('0),
        .den_in (front.den6),
        .quo    (hue_q)
    );

    // saturation: 255 * span / max, high byte of the numerator is below max
    hsv_div #(
        .DW    (CH_W),
        .QBITS (SAT_W),
        .NSTG  (NS),
        .STEP  (DIV_STEP)
    ) u_sat_div (
        .clk    (clk),
        .en     (en[NS:1]),
        .rem_in (front.sat_num[SAT_NUM_W-1:CH_W]),
        .num_in (front.sat_num[CH_W-1:0]),
        .den_in (front.value),
        .quo    (sat_q)
    );

    // value and zero flags ride alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[0] <= '{value: front.value, hue_zero: front.hue_zero,
                             sat_zero: front.sat_zero};
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i+1])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // grey and black pixels force zero results
    always_comb
    begin
        hue_next = side_reg[NS-1].hue_zero ? '0 : HUE_W'(hue_q);
        sat_next = side_reg[NS-1].sat_zero ? '0 : sat_q;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en[NT-1])
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= side_reg[NS-1].value;
        end
    end

    assign m_axis_tdata = {value_reg, sat_reg, hue_reg};

    // black pixel gives zero hue and saturation
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (value_reg == '0) |-> (sat_reg == '0) && (hue_reg == '0))
        else $error("black pixel with nonzero hue or saturation");

    // a colored hue needs a nonzero span, hence nonzero saturation
    a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (hue_reg != '0) |-> (sat_reg != '0))
        else $error("nonzero hue with zero saturation");

    // input is refused only when every stage holds a pixel
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&valid_reg) && !m_axis_tready)
        else $error("input stalled with a free stage");

endmodule
